// ===== hw/rtl/ewmaad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ewmaad_pkg: shared types and constants of the moving-average activity detector
// This package holds the register field widths, the register indexes, the
// register reset values, the sequencer states and the control structs.
// ---------------------------------------------------------------------------
package ewmaad_pkg;

	// Widths of the configuration register fields.
	localparam int THRESH_W = 10;
	localparam int MGAIN_W  = 20;
	localparam int DGAIN_W  = 16;
	localparam int TICK_W   = 8;
	localparam int CNT_W    = 4;

	// Width of the deviation field in the result word.
	localparam int DEVOUT_W = 10;

	// Fixed-point fractions of the two gains.
	localparam int MEAN_GAIN_FRAC = 20;
	localparam int DEV_GAIN_FRAC  = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVITY_THRESHOLD = 3'd0,
		CFG_MEAN_GAIN          = 3'd1,
		CFG_DEV_GAIN           = 3'd2,
		CFG_BLINK_TICKS        = 3'd3,
		CFG_WINDOW_TICKS       = 3'd4,
		CFG_BURST_EVENTS       = 3'd5,
		CFG_BURST_BLINK_TICKS  = 3'd6
	} cfg_idx_t;

	// Register reset values.
	localparam logic [THRESH_W-1:0] RST_ACTIVITY_THRESHOLD = 10'd8;
	localparam logic [MGAIN_W-1:0]  RST_MEAN_GAIN          = 20'd1049;
	localparam logic [DGAIN_W-1:0]  RST_DEV_GAIN           = 16'd6554;
	localparam logic [TICK_W-1:0]   RST_BLINK_TICKS        = 8'd50;
	localparam logic [TICK_W-1:0]   RST_WINDOW_TICKS       = 8'd100;
	localparam logic [CNT_W-1:0]    RST_BURST_EVENTS       = 4'd4;
	localparam logic [TICK_W-1:0]   RST_BURST_BLINK_TICKS  = 8'd100;

	// Blink timer value after reset.
	localparam logic [TICK_W-1:0]   RST_BLINK_LEFT = 8'd5;

	// Event counter ceiling.
	localparam logic [CNT_W-1:0]    CNT_MAX = 4'd15;

	typedef struct packed {
		logic [THRESH_W-1:0] activity_threshold;
		logic [MGAIN_W-1:0]  mean_gain;
		logic [DGAIN_W-1:0]  dev_gain;
		logic [TICK_W-1:0]   blink_ticks;
		logic [TICK_W-1:0]   window_ticks;
		logic [CNT_W-1:0]    burst_events;
		logic [TICK_W-1:0]   burst_blink_ticks;
	} cfg_t;

	// Sequencer states, one per use of the shared datapath.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAG,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_UPD,
		ST_ABSD,
		ST_DEV1,
		ST_DEV2,
		ST_DEVSUM,
		ST_STEP
	} seq_state_t;

	// Strobes from the sequencer to the datapath and the event logic.
	typedef struct packed {
		logic take;
		logic mag;
		logic mul_lo;
		logic mul_hi;
		logic upd;
		logic absd;
		logic dev1;
		logic dev2;
		logic devsum;
		logic step;
	} ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ewmaad_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ewmaad_if: sample and result channels
// Valid/ready channels that carry one sample word in and one result word out.
// ---------------------------------------------------------------------------
interface ewmaad_in_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface ewmaad_out_if;
	logic                             valid;
	logic                             ready;
	logic                             activity;
	logic                             event_led;
	logic                             burst_led;
	logic [ewmaad_pkg::DEVOUT_W-1:0]  deviation_level;
	logic [ewmaad_pkg::CNT_W-1:0]     events_seen;

	modport source (output valid, output activity, output event_led, output burst_led,
		output deviation_level, output events_seen, input ready);
	modport sink   (input valid, input activity, input event_led, input burst_led,
		input deviation_level, input events_seen, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ewma_activity_detector_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ewma_activity_detector_top: moving-average activity detector
// Tracks a slow mean of the samples and the mean absolute deviation from
// it, flags activity above a threshold and drives event and burst lights.
//
//   channel     dir  handshake      word
//   sample_ch   in   valid/ready    sample
//   result_ch   out  valid/ready    activity, event_led, burst_led,
//                                   deviation_level, events_seen
//   cfg         in   cfg_wr_en      cfg_index, cfg_data
//
// A sample goes from acceptance to its result through one accept step
// and nine sequencer steps, four of them on the single shared multiplier.
// The next sample is taken in the cycle after the result is latched.
// Reset is asynchronous and returns the mean, deviation and timers to zero,
// with the blink timer at five and the registers at their defaults.
// A stalled result holds in its register; the sequencer waits in the event
// step only when that register is still occupied.
// ---------------------------------------------------------------------------
module ewma_activity_detector_top #(
	parameter int SAMPLE_BITS    = 10,
	parameter int MEAN_FRAC_BITS = 20
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [ewmaad_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ewmaad_pkg::CFG_DATA_W-1:0]  cfg_data,
	ewmaad_in_if.sink                               sample_ch,
	ewmaad_out_if.source                            result_ch
);

	ewmaad_pkg::cfg_t       cfg;
	ewmaad_pkg::ctl_t       ctl;
	logic                   out_valid_q;
	logic                   out_free;
	logic [SAMPLE_BITS-1:0] deviation;

	assign out_free = !out_valid_q || result_ch.ready;

	ewmaad_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ewmaad_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.out_free (out_free),
		.in_ready (sample_ch.ready),
		.ctl      (ctl)
	);

	ewmaad_avg_dp #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.MEAN_FRAC_BITS (MEAN_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sample    (sample_ch.sample),
		.mean_gain (cfg.mean_gain),
		.dev_gain  (cfg.dev_gain),
		.deviation (deviation)
	);

	ewmaad_event_ctrl #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_evt (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (ctl.step),
		.deviation       (deviation),
		.cfg             (cfg),
		.activity        (result_ch.activity),
		.event_led       (result_ch.event_led),
		.burst_led       (result_ch.burst_led),
		.deviation_level (result_ch.deviation_level),
		.events_seen     (result_ch.events_seen)
	);

	// Result valid: set when a word is latched, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.step) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid = out_valid_q;

	// A taken sample keeps the input closed on the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
		else $error("input reopened right after a sample was taken");

	// A finished sample always shows up as a valid result word.
	a_step_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |=> result_ch.valid)
		else $error("result word not presented after the event step");

endmodule
`default_nettype wire

// ===== hw/rtl/ewmaad_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ewmaad_cfg_regs: configuration register file
// Seven write-only registers, each masked to its own width on write.
// ---------------------------------------------------------------------------
module ewmaad_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [ewmaad_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ewmaad_pkg::CFG_DATA_W-1:0]  cfg_data,
	output      ewmaad_pkg::cfg_t                   cfg
);

	ewmaad_pkg::cfg_t cfg_q;

	// Register writes; an index with no register behind it is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.activity_threshold <= ewmaad_pkg::RST_ACTIVITY_THRESHOLD;
			cfg_q.mean_gain          <= ewmaad_pkg::RST_MEAN_GAIN;
			cfg_q.dev_gain           <= ewmaad_pkg::RST_DEV_GAIN;
			cfg_q.blink_ticks        <= ewmaad_pkg::RST_BLINK_TICKS;
			cfg_q.window_ticks       <= ewmaad_pkg::RST_WINDOW_TICKS;
			cfg_q.burst_events       <= ewmaad_pkg::RST_BURST_EVENTS;
			cfg_q.burst_blink_ticks  <= ewmaad_pkg::RST_BURST_BLINK_TICKS;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ewmaad_pkg::CFG_ACTIVITY_THRESHOLD: begin
					cfg_q.activity_threshold <= cfg_data[ewmaad_pkg::THRESH_W-1:0];
				end
				ewmaad_pkg::CFG_MEAN_GAIN: begin
					cfg_q.mean_gain <= cfg_data[ewmaad_pkg::MGAIN_W-1:0];
				end
				ewmaad_pkg::CFG_DEV_GAIN: begin
					cfg_q.dev_gain <= cfg_data[ewmaad_pkg::DGAIN_W-1:0];
				end
				ewmaad_pkg::CFG_BLINK_TICKS: begin
					cfg_q.blink_ticks <= cfg_data[ewmaad_pkg::TICK_W-1:0];
				end
				ewmaad_pkg::CFG_WINDOW_TICKS: begin
					cfg_q.window_ticks <= cfg_data[ewmaad_pkg::TICK_W-1:0];
				end
				ewmaad_pkg::CFG_BURST_EVENTS: begin
					cfg_q.burst_events <= cfg_data[ewmaad_pkg::CNT_W-1:0];
				end
				ewmaad_pkg::CFG_BURST_BLINK_TICKS: begin
					cfg_q.burst_blink_ticks <= cfg_data[ewmaad_pkg::TICK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ewmaad_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ewmaad_seq: sequencer of the shared datapath
// Walks one sample through the mean, difference and deviation steps and
// then the event step, which waits until the result register is free.
// ---------------------------------------------------------------------------
module ewmaad_seq (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        out_free,
	output wire logic        in_ready,
	output ewmaad_pkg::ctl_t ctl
);

	ewmaad_pkg::seq_state_t state_q;
	ewmaad_pkg::seq_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ewmaad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and step strobes.
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ewmaad_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctl.take = 1'b1;
					state_d  = ewmaad_pkg::ST_MAG;
				end
			end
			ewmaad_pkg::ST_MAG: begin
				ctl.mag = 1'b1;
				state_d = ewmaad_pkg::ST_MUL_LO;
			end
			ewmaad_pkg::ST_MUL_LO: begin
				ctl.mul_lo = 1'b1;
				state_d    = ewmaad_pkg::ST_MUL_HI;
			end
			ewmaad_pkg::ST_MUL_HI: begin
				ctl.mul_hi = 1'b1;
				state_d    = ewmaad_pkg::ST_UPD;
			end
			ewmaad_pkg::ST_UPD: begin
				ctl.upd = 1'b1;
				state_d = ewmaad_pkg::ST_ABSD;
			end
			ewmaad_pkg::ST_ABSD: begin
				ctl.absd = 1'b1;
				state_d  = ewmaad_pkg::ST_DEV1;
			end
			ewmaad_pkg::ST_DEV1: begin
				ctl.dev1 = 1'b1;
				state_d  = ewmaad_pkg::ST_DEV2;
			end
			ewmaad_pkg::ST_DEV2: begin
				ctl.dev2 = 1'b1;
				state_d  = ewmaad_pkg::ST_DEVSUM;
			end
			ewmaad_pkg::ST_DEVSUM: begin
				ctl.devsum = 1'b1;
				state_d    = ewmaad_pkg::ST_STEP;
			end
			ewmaad_pkg::ST_STEP: begin
				if (out_free) begin
					ctl.step = 1'b1;
					state_d  = ewmaad_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ewmaad_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ewmaad_pkg::ST_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/ewmaad_avg_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ewmaad_avg_dp: averaging datapath around one shared multiplier
// Holds the running mean and the running mean absolute deviation. The
// mean step is formed from two half-width partial products and the
// deviation from two products, all through the same registered multiplier.
// ---------------------------------------------------------------------------
module ewmaad_avg_dp #(
	parameter int SAMPLE_BITS    = 10,
	parameter int MEAN_FRAC_BITS = 20
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ewmaad_pkg::ctl_t                  ctl,
	input  wire logic [SAMPLE_BITS-1:0]            sample,
	input  wire logic [ewmaad_pkg::MGAIN_W-1:0]    mean_gain,
	input  wire logic [ewmaad_pkg::DGAIN_W-1:0]    dev_gain,
	output wire logic [SAMPLE_BITS-1:0]            deviation
);

	localparam int MW  = SAMPLE_BITS + MEAN_FRAC_BITS;
	localparam int HW  = (MW + 1) / 2;
	localparam int AW  = (HW > SAMPLE_BITS) ? HW : SAMPLE_BITS;
	localparam int BW  = ewmaad_pkg::MGAIN_W;
	localparam int PW  = AW + BW;
	localparam int SW  = MW + BW + 1;
	localparam int DGF = ewmaad_pkg::DEV_GAIN_FRAC;
	localparam int DGAIN_W1 = ewmaad_pkg::DGAIN_W + 1;
	// Smallest mean that counts as settled: 0.001 rounded up.
	localparam logic [MW-1:0] LOAD_LIMIT =
		MW'(((64'd1 << MEAN_FRAC_BITS) + 64'd999) / 64'd1000);

	logic [SAMPLE_BITS-1:0] x_q;
	logic [MW-1:0]          mean_q;
	logic [MW-1:0]          mag_q;
	logic                   neg_q;
	logic [SAMPLE_BITS-1:0] a_q;
	logic [SAMPLE_BITS-1:0] dev_q;
	logic [PW-1:0]          prod_q;
	logic [PW-1:0]          acc_q;

	logic [MW-1:0]          xs;
	logic                   load;
	logic [MW-1:0]          mean_eff;
	logic                   mag_neg;
	logic [MW-1:0]          mag;
	logic [AW-1:0]          mul_a;
	logic [BW-1:0]          mul_b;
	logic [DGAIN_W1-1:0]    inv_gain;
	logic [SW-1:0]          msum;
	logic [MW-1:0]          mstep;
	logic [MW-1:0]          adiff;
	logic [PW:0]            dsum;

	assign xs = {x_q, MEAN_FRAC_BITS'(0)};

	// Mean load below the settle limit, then the distance to the sample.
	always_comb begin
		load     = (mean_q < LOAD_LIMIT);
		mean_eff = load ? xs : mean_q;
		mag_neg  = (xs < mean_eff);
		mag      = mag_neg ? (mean_eff - xs) : (xs - mean_eff);
	end

	// Complement of the deviation gain, one in Q1.16 minus the gain.
	assign inv_gain = DGAIN_W1'(1 << DGF) - {1'b0, dev_gain};

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		priority if (ctl.mul_lo) begin
			mul_a = AW'(mag_q[HW-1:0]);
			mul_b = mean_gain;
		end else if (ctl.mul_hi) begin
			mul_a = AW'(mag_q[MW-1:HW]);
			mul_b = mean_gain;
		end else if (ctl.dev1) begin
			mul_a = AW'(dev_q);
			mul_b = BW'(inv_gain);
		end else if (ctl.dev2) begin
			mul_a = AW'(a_q);
			mul_b = BW'(dev_gain);
		end
	end

	// Mean step: sum of the partial products, truncated toward zero.
	always_comb begin
		msum  = SW'(acc_q) + (SW'(prod_q) << HW);
		mstep = msum[ewmaad_pkg::MEAN_GAIN_FRAC +: MW];
	end

	// Whole-sample distance between the sample and the new mean.
	assign adiff = (xs >= mean_q) ? (xs - mean_q) : (mean_q - xs);

	// Deviation sum of both weighted products.
	assign dsum = (PW + 1)'(acc_q) + (PW + 1)'(prod_q);

	// Multiplier output and partial sum registers.
	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
		if (ctl.mul_hi || ctl.dev2) begin
			acc_q <= prod_q;
		end
		if (ctl.take) begin
			x_q <= sample;
		end
		if (ctl.mag) begin
			mag_q <= mag;
			neg_q <= mag_neg;
		end
		if (ctl.absd) begin
			a_q <= adiff[MW-1:MEAN_FRAC_BITS];
		end
	end

	// Running mean and deviation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			dev_q  <= '0;
		end else begin
			if (ctl.mag) begin
				mean_q <= mean_eff;
			end else if (ctl.upd) begin
				mean_q <= neg_q ? (mean_q - mstep) : (mean_q + mstep);
			end
			if (ctl.devsum) begin
				dev_q <= dsum[DGF +: SAMPLE_BITS];
			end
		end
	end

	assign deviation = dev_q;

	// A sample above the mean never moves the mean down.
	a_mean_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.upd && !neg_q) |=> (mean_q >= $past(mean_q)))
		else $error("mean moved away from the sample");

	// The new deviation never exceeds the larger of old deviation and distance.
	a_dev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.devsum |=> ((dev_q <= $past(dev_q)) || (dev_q <= $past(a_q))))
		else $error("deviation grew past both of its inputs");

endmodule
`default_nettype wire

// ===== hw/rtl/ewmaad_event_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ewmaad_event_ctrl: event, window and burst logic with the result register
// Once per sample it decides activity, runs the blink and window timers,
// counts events and fires the burst indicator, and latches the result word.
// ---------------------------------------------------------------------------
module ewmaad_event_ctrl #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire logic [SAMPLE_BITS-1:0]            deviation,
	input  wire ewmaad_pkg::cfg_t                  cfg,
	output wire logic                              activity,
	output wire logic                              event_led,
	output wire logic                              burst_led,
	output wire logic [ewmaad_pkg::DEVOUT_W-1:0]   deviation_level,
	output wire logic [ewmaad_pkg::CNT_W-1:0]      events_seen
);

	localparam int CW = SAMPLE_BITS + ewmaad_pkg::THRESH_W;
	localparam int LW = SAMPLE_BITS + ewmaad_pkg::DEVOUT_W;

	logic                              act_q;
	logic [ewmaad_pkg::DEVOUT_W-1:0]   lvl_q;
	logic                              event_accounted_q;
	logic [ewmaad_pkg::TICK_W-1:0]     blink_left_q;
	logic [ewmaad_pkg::TICK_W-1:0]     window_left_q;
	logic [ewmaad_pkg::CNT_W-1:0]      event_count_q;
	logic                              event_light_q;
	logic                              burst_light_q;

	logic                              act;
	logic [LW-1:0]                     dev_wide;
	logic                              accounted_d;
	logic [ewmaad_pkg::TICK_W-1:0]     blink_d;
	logic [ewmaad_pkg::TICK_W-1:0]     window_d;
	logic [ewmaad_pkg::CNT_W-1:0]      count_d;
	logic                              event_d;
	logic                              burst_d;

	assign act      = (CW'(deviation) >= CW'(cfg.activity_threshold));
	assign dev_wide = LW'(deviation);

	// One tick of the event controls, in their fixed order.
	always_comb begin
		accounted_d = event_accounted_q;
		blink_d     = blink_left_q;
		window_d    = window_left_q;
		count_d     = event_count_q;
		event_d     = event_light_q;
		burst_d     = burst_light_q;

		// A new activity starts an event.
		if (act && !accounted_d) begin
			event_d     = 1'b1;
			blink_d     = cfg.blink_ticks;
			if (count_d != ewmaad_pkg::CNT_MAX) begin
				count_d = count_d + 1'b1;
			end
			window_d    = cfg.window_ticks;
			accounted_d = 1'b1;
		end

		// Blink timer; at zero both lights go out.
		if (blink_d == '0) begin
			event_d     = 1'b0;
			burst_d     = 1'b0;
			accounted_d = 1'b0;
		end else begin
			blink_d = blink_d - 1'b1;
		end

		// Window timer; at zero the event count clears.
		if (window_d == '0) begin
			count_d = '0;
		end else begin
			window_d = window_d - 1'b1;
		end

		// Enough events in the window fire a burst.
		if (count_d == cfg.burst_events) begin
			burst_d  = 1'b1;
			count_d  = '0;
			blink_d  = cfg.burst_blink_ticks;
			window_d = cfg.window_ticks;
		end
	end

	// Event state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_accounted_q <= 1'b0;
			blink_left_q      <= ewmaad_pkg::RST_BLINK_LEFT;
			window_left_q     <= '0;
			event_count_q     <= '0;
			event_light_q     <= 1'b0;
			burst_light_q     <= 1'b0;
		end else if (step) begin
			event_accounted_q <= accounted_d;
			blink_left_q      <= blink_d;
			window_left_q     <= window_d;
			event_count_q     <= count_d;
			event_light_q     <= event_d;
			burst_light_q     <= burst_d;
		end
	end

	// Result word fields that are not part of the event state.
	always_ff @(posedge clk) begin
		if (step) begin
			act_q <= act;
			lvl_q <= dev_wide[ewmaad_pkg::DEVOUT_W-1:0];
		end
	end

	assign activity        = act_q;
	assign event_led       = event_light_q;
	assign burst_led       = burst_light_q;
	assign deviation_level = lvl_q;
	assign events_seen     = event_count_q;

	// The event light and the accounted flag are set and cleared together.
	a_light_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		event_light_q == event_accounted_q)
		else $error("event light and accounted flag disagree");

endmodule
`default_nettype wire

// ===== bench/tb_ewma_activity_detector_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ewma_activity_detector_top: self-checking bench of the activity detector
// Samples go in over the valid/ready channel with random gaps. Result words
// are taken with random stalls and checked field by field against a mirror
// of the mean, deviation, event and burst logic. The run goes through a
// directed opening and then several register settings with shaped random
// sample streams of quiet and loud stretches.
// ---------------------------------------------------------------------------
module tb_ewma_activity_detector_top;

	localparam int SAMPLE_W   = 10;
	localparam int MEAN_FRAC  = 20;
	localparam int CFG_W      = ewmaad_pkg::CFG_DATA_W;
	localparam longint unsigned LOAD_LIMIT = ((64'd1 << MEAN_FRAC) + 64'd999) / 64'd1000;
	localparam longint unsigned DEV_ONE    = 64'd1 << ewmaad_pkg::DEV_GAIN_FRAC;
	localparam logic [ewmaad_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
	localparam int MAX_REPORTS   = 10;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PHASES = 11;
	localparam int PHASE_WORDS   = 55;
	localparam int CYCLE_LIMIT   = 500000;
	localparam logic [8*SAMPLE_W-1:0] CORNERS = {10'd0, 10'd1023, 10'd0, 10'd1023,
		10'h155, 10'h2AA, 10'd1023, 10'd0};

	typedef struct packed {
		logic                            activity;
		logic                            event_led;
		logic                            burst_led;
		logic [ewmaad_pkg::DEVOUT_W-1:0] deviation_level;
		logic [ewmaad_pkg::CNT_W-1:0]    events_seen;
	} result_word_t;

	// Mirror of the detector: registers, averages, timers and the words still due.
	class activity_mirror;
		logic [ewmaad_pkg::THRESH_W-1:0] threshold;
		logic [ewmaad_pkg::MGAIN_W-1:0]  mean_gain;
		logic [ewmaad_pkg::DGAIN_W-1:0]  dev_gain;
		logic [ewmaad_pkg::TICK_W-1:0]   blink_ticks;
		logic [ewmaad_pkg::TICK_W-1:0]   window_ticks;
		logic [ewmaad_pkg::CNT_W-1:0]    burst_events;
		logic [ewmaad_pkg::TICK_W-1:0]   burst_blink_ticks;
		longint unsigned                 mean_q;
		logic [ewmaad_pkg::DEVOUT_W-1:0] dev_q;
		logic                            accounted;
		logic [ewmaad_pkg::TICK_W-1:0]   blink_left;
		logic [ewmaad_pkg::TICK_W-1:0]   window_left;
		logic [ewmaad_pkg::CNT_W-1:0]    event_count;
		logic                            event_light;
		logic                            burst_light;
		result_word_t                    due_words[$];
		int unsigned                     bad_words;
		int unsigned                     words_seen;

		function new();
			threshold         = ewmaad_pkg::RST_ACTIVITY_THRESHOLD;
			mean_gain         = ewmaad_pkg::RST_MEAN_GAIN;
			dev_gain          = ewmaad_pkg::RST_DEV_GAIN;
			blink_ticks       = ewmaad_pkg::RST_BLINK_TICKS;
			window_ticks      = ewmaad_pkg::RST_WINDOW_TICKS;
			burst_events      = ewmaad_pkg::RST_BURST_EVENTS;
			burst_blink_ticks = ewmaad_pkg::RST_BURST_BLINK_TICKS;
			mean_q      = 0;
			dev_q       = '0;
			accounted   = 1'b0;
			blink_left  = ewmaad_pkg::RST_BLINK_LEFT;
			window_left = '0;
			event_count = '0;
			event_light = 1'b0;
			burst_light = 1'b0;
			bad_words   = 0;
			words_seen  = 0;
		endfunction

		// Register writes keep only the bits of the register; unknown indexes do nothing.
		function void set_reg(logic [ewmaad_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				ewmaad_pkg::CFG_ACTIVITY_THRESHOLD:
					threshold = data[ewmaad_pkg::THRESH_W-1:0];
				ewmaad_pkg::CFG_MEAN_GAIN:
					mean_gain = data[ewmaad_pkg::MGAIN_W-1:0];
				ewmaad_pkg::CFG_DEV_GAIN:
					dev_gain = data[ewmaad_pkg::DGAIN_W-1:0];
				ewmaad_pkg::CFG_BLINK_TICKS:
					blink_ticks = data[ewmaad_pkg::TICK_W-1:0];
				ewmaad_pkg::CFG_WINDOW_TICKS:
					window_ticks = data[ewmaad_pkg::TICK_W-1:0];
				ewmaad_pkg::CFG_BURST_EVENTS:
					burst_events = data[ewmaad_pkg::CNT_W-1:0];
				ewmaad_pkg::CFG_BURST_BLINK_TICKS:
					burst_blink_ticks = data[ewmaad_pkg::TICK_W-1:0];
				default: ;
			endcase
		endfunction

		// One tick of the detector for an accepted sample.
		function void take_sample(logic [SAMPLE_W-1:0] x);
			longint unsigned scaled;
			longint unsigned mag;
			longint unsigned absd;
			longint unsigned mix;
			logic            hit;
			result_word_t    w;
			scaled = x;
			scaled = scaled << MEAN_FRAC;
			// A mean still below 0.001 is loaded with the sample.
			if (mean_q < LOAD_LIMIT)
				mean_q = scaled;
			// The mean step is truncated toward zero on either side.
			if (scaled >= mean_q) begin
				mag    = scaled - mean_q;
				mean_q = mean_q + ((mag * mean_gain) >> ewmaad_pkg::MEAN_GAIN_FRAC);
			end else begin
				mag    = mean_q - scaled;
				mean_q = mean_q - ((mag * mean_gain) >> ewmaad_pkg::MEAN_GAIN_FRAC);
			end
			absd = ((scaled >= mean_q) ? (scaled - mean_q) : (mean_q - scaled)) >> MEAN_FRAC;
			mix  = dev_q * (DEV_ONE - dev_gain) + dev_gain * absd;
			dev_q = mix >> ewmaad_pkg::DEV_GAIN_FRAC;
			hit   = (dev_q >= threshold);

			// A new activity lights the event LED and counts one event.
			if (hit && !accounted) begin
				event_light = 1'b1;
				blink_left  = blink_ticks;
				if (event_count < ewmaad_pkg::CNT_MAX)
					event_count = event_count + 1'b1;
				window_left = window_ticks;
				accounted   = 1'b1;
			end
			// An expired blink timer puts both LEDs out.
			if (blink_left == 0) begin
				event_light = 1'b0;
				burst_light = 1'b0;
				accounted   = 1'b0;
			end else begin
				blink_left = blink_left - 1'b1;
			end
			if (window_left == 0)
				event_count = '0;
			else
				window_left = window_left - 1'b1;
			// Enough events in the window fire a burst.
			if (event_count == burst_events) begin
				burst_light = 1'b1;
				event_count = '0;
				blink_left  = burst_blink_ticks;
				window_left = window_ticks;
			end

			w.activity        = hit;
			w.event_led       = event_light;
			w.burst_led       = burst_light;
			w.deviation_level = dev_q;
			w.events_seen     = event_count;
			due_words.push_back(w);
		endfunction

		// Compare one received word with the oldest word still due.
		function void compare_word(result_word_t got);
			result_word_t want;
			words_seen++;
			if (due_words.size() == 0) begin
				bad_words++;
				if (bad_words <= MAX_REPORTS)
					$display({"word %0d arrived with none due: ",
						"act=%0b ev=%0b burst=%0b dev=%0d cnt=%0d"},
						words_seen, got.activity, got.event_led, got.burst_led,
						got.deviation_level, got.events_seen);
				return;
			end
			want = due_words.pop_front();
			if (got.activity !== want.activity || got.event_led !== want.event_led ||
					got.burst_led !== want.burst_led ||
					got.deviation_level !== want.deviation_level ||
					got.events_seen !== want.events_seen) begin
				bad_words++;
				if (bad_words <= MAX_REPORTS)
					$display({"word %0d: expected act=%0b ev=%0b burst=%0b dev=%0d cnt=%0d, ",
						"got act=%0b ev=%0b burst=%0b dev=%0d cnt=%0d"},
						words_seen, want.activity, want.event_led, want.burst_led,
						want.deviation_level, want.events_seen, got.activity, got.event_led,
						got.burst_led, got.deviation_level, got.events_seen);
			end
		endfunction

		function int unsigned failures();
			return bad_words + due_words.size();
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_wr_en;
	logic [ewmaad_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]                    cfg_data;
	logic                                gaps_on;
	logic                                stalls_on;
	int unsigned                         stall_left = 0;
	int unsigned                         cycle_count = 0;
	int                                  level = 512;
	int unsigned                         span_left = 0;
	logic                                loud = 1'b0;
	activity_mirror                      mirror = new();

	ewmaad_in_if #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();
	ewmaad_out_if                           result_ch ();

	ewma_activity_detector_top #(
		.SAMPLE_BITS    (SAMPLE_W),
		.MEAN_FRAC_BITS (MEAN_FRAC)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The run is cut off if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ewma_activity_detector_top: mismatch");
			$finish;
		end
	end

	// Mostly short pauses, now and then a long one.
	function automatic int unsigned pick_pause();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result side: take words with random stalls and check each one.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			mirror.compare_word({result_ch.activity, result_ch.event_led, result_ch.burst_led,
				result_ch.deviation_level, result_ch.events_seen});
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ch.ready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 99) < 20) begin
			stall_left <= pick_pause() - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Sensor-like stream: quiet stretches around a level, loud stretches, a little noise.
	function automatic logic [SAMPLE_W-1:0] next_sample();
		int v;
		int unsigned r;
		if (span_left == 0) begin
			loud = !loud;
			span_left = loud ? $urandom_range(1, 8) : $urandom_range(3, 30);
			r = $urandom_range(0, 9);
			if (r == 0)
				level = 0;
			else if (r == 1)
				level = 1023;
			else if (r < 4)
				level = $urandom_range(0, 1023);
		end
		span_left--;
		r = $urandom_range(0, 99);
		if (r < 5)
			v = $urandom_range(0, 1023);
		else if (loud && r < 40)
			v = $urandom_range(0, 1023);
		else if (loud)
			v = level + int'($urandom_range(0, 400)) - 200;
		else
			v = level + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[SAMPLE_W-1:0];
	endfunction

	// Register settings: the high extremes, the low gains, or a random mix.
	function automatic ewmaad_pkg::cfg_t pick_settings(int kind);
		ewmaad_pkg::cfg_t c;
		int unsigned r;
		r = $urandom_range(0, 9);
		c.activity_threshold = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 :
			10'($urandom_range(1, 40));
		r = $urandom_range(0, 9);
		c.mean_gain = (r == 0) ? 20'd1 : (r == 1) ? 20'hFFFFF : (r == 2) ? 20'd0 :
			(r < 6) ? 20'($urandom_range(1, 20'hFFFFF)) : 20'($urandom_range(500, 60000));
		r = $urandom_range(0, 9);
		c.dev_gain = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd0 :
			16'($urandom_range(1, 65535));
		r = $urandom_range(0, 9);
		c.blink_ticks = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 12));
		r = $urandom_range(0, 9);
		c.window_ticks = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 40));
		c.burst_events = 4'($urandom_range(0, 15));
		r = $urandom_range(0, 9);
		c.burst_blink_ticks = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
			8'($urandom_range(0, 12));
		if (kind == 1) begin
			c.activity_threshold = 10'd1023;
			c.mean_gain          = 20'hFFFFF;
			c.dev_gain           = 16'hFFFF;
			c.blink_ticks        = 8'd255;
			c.window_ticks       = 8'd255;
			c.burst_events       = 4'd15;
			c.burst_blink_ticks  = 8'd255;
		end else if (kind == 2) begin
			c.mean_gain = 20'd1;
			c.dev_gain  = 16'd1;
		end
		return c;
	endfunction

	// Sometimes set bits above the register width; the block must drop them.
	function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] v, int w);
		logic [CFG_W-1:0] hi;
		hi = CFG_W'($urandom);
		hi = hi & ~((CFG_W'(1) << w) - CFG_W'(1));
		return ($urandom_range(0, 3) == 0) ? (v | hi) : v;
	endfunction

	task automatic write_reg(input logic [ewmaad_pkg::CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		mirror.set_reg(idx, data);
	endtask

	task automatic program_regs(input ewmaad_pkg::cfg_t c);
		write_reg(ewmaad_pkg::CFG_ACTIVITY_THRESHOLD,
			with_junk(CFG_W'(c.activity_threshold), ewmaad_pkg::THRESH_W));
		write_reg(ewmaad_pkg::CFG_MEAN_GAIN,
			with_junk(CFG_W'(c.mean_gain), ewmaad_pkg::MGAIN_W));
		write_reg(ewmaad_pkg::CFG_DEV_GAIN,
			with_junk(CFG_W'(c.dev_gain), ewmaad_pkg::DGAIN_W));
		write_reg(ewmaad_pkg::CFG_BLINK_TICKS,
			with_junk(CFG_W'(c.blink_ticks), ewmaad_pkg::TICK_W));
		write_reg(ewmaad_pkg::CFG_WINDOW_TICKS,
			with_junk(CFG_W'(c.window_ticks), ewmaad_pkg::TICK_W));
		write_reg(ewmaad_pkg::CFG_BURST_EVENTS,
			with_junk(CFG_W'(c.burst_events), ewmaad_pkg::CNT_W));
		write_reg(ewmaad_pkg::CFG_BURST_BLINK_TICKS,
			with_junk(CFG_W'(c.burst_blink_ticks), ewmaad_pkg::TICK_W));
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_NO_REG, CFG_W'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	// Offer one sample and hold it until the block takes it.
	task automatic send_sample(input logic [SAMPLE_W-1:0] x);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= x;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		mirror.take_sample(x);
	endtask

	// Wait until every due word is back and the sequencer has gone idle.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (mirror.due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int ph;
		int n;
		ewmaad_pkg::cfg_t settings;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = ewmaad_pkg::CFG_ACTIVITY_THRESHOLD;
		cfg_data         = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready  = 1'b0;
		gaps_on          = 1'b0;
		stalls_on        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: sample extremes and alternating bit patterns.
		for (n = 0; n < 8; n++)
			send_sample(CORNERS[n*SAMPLE_W +: SAMPLE_W]);
		drain();

		// Frozen averages, zero threshold and blink times, full window, burst count of zero:
		// every tick is an event and the event count saturates.
		write_reg(ewmaad_pkg::CFG_ACTIVITY_THRESHOLD, 20'hFFC00);
		write_reg(ewmaad_pkg::CFG_MEAN_GAIN, 20'd0);
		write_reg(ewmaad_pkg::CFG_DEV_GAIN, 20'hF0000);
		write_reg(ewmaad_pkg::CFG_BLINK_TICKS, 20'hFFF00);
		write_reg(ewmaad_pkg::CFG_WINDOW_TICKS, 20'hFFFFF);
		write_reg(ewmaad_pkg::CFG_BURST_EVENTS, 20'hFFFF0);
		write_reg(ewmaad_pkg::CFG_BURST_BLINK_TICKS, 20'd0);
		write_reg(CFG_NO_REG, 20'h5A5A5);
		cfg_wr_en <= 1'b0;
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		for (n = 0; n < 17; n++)
			send_sample(SAMPLE_W'($urandom_range(0, 1023)));
		drain();

		// Random phases, each under its own settings and idling mix.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			settings = pick_settings((ph == 1) ? 1 : (ph == 2) ? 2 : 0);
			program_regs(settings);
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			for (n = 0; n < PHASE_WORDS; n++)
				send_sample(next_sample());
			drain();
		end

		if (mirror.failures() == 0)
			$display("ewma_activity_detector_top: match");
		else
			$display("ewma_activity_detector_top: mismatch");
		$finish;
	end

endmodule
